// File: rtl/fwps_pkg.sv
// Shared types and constants for the fixed-weight position sampler.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package fwps_pkg;

    // Stream geometry
    localparam int POS_BITS    = 10;
    localparam int BLOCK_BYTES = 168;
    localparam int BYTE_W      = 8;

    // Visited map
    localparam int MAP_DEPTH = 1 << POS_BITS;
    localparam int EPOCH_W   = 6;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX   = {EPOCH_W{1'b1}};
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

    // Bit buffer: at most POS_BITS-1 leftover bits plus one new byte
    localparam int BUF_W = POS_BITS + BYTE_W - 1;
    localparam int CNT_W = $clog2(BUF_W + 1);
    localparam int BIB_W = $clog2(BLOCK_BYTES);

    // Run bookkeeping
    localparam int FOUND_W    = 7;
    localparam int SLOT_W     = 6;
    localparam int MAX_WEIGHT = 64;
    localparam logic [FOUND_W-1:0] WEIGHT_RESET = FOUND_W'(44);

    // Result stream packing: position in the low bits, slot above
    localparam int M_TDATA_W = ((POS_BITS + SLOT_W + 7) / 8) * 8;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_WEIGHT = '0;

    // One byte after unpacking: candidate position plus run tagging
    typedef struct packed {
        logic [POS_BITS-1:0] pos;
        logic                has_pos;
        logic                start;
        logic [EPOCH_W-1:0]  epoch;
    } cand_t;

    // Write request into the visited map
    typedef struct packed {
        logic                en;
        logic [POS_BITS-1:0] addr;
        logic [EPOCH_W-1:0]  data;
    } map_wr_t;

endpackage

// File: rtl/fwps_map.sv
// Visited map RAM: one epoch tag per position, one write and one read port.
// Depends on fwps_pkg for depth and tag width.
`timescale 1ns / 1ps

module fwps_map
    import fwps_pkg::*;
(
    input  logic                aclk,
    input  map_wr_t             wr,
    input  logic                rd_en,
    input  logic [POS_BITS-1:0] rd_addr,
    output logic [EPOCH_W-1:0]  rd_data
);

    logic [EPOCH_W-1:0] mem [MAP_DEPTH];
    logic [EPOCH_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/fwps_unpack.sv
// Byte-to-position unpacker: little-endian bit buffer with block boundary drop.
// Depends on fwps_pkg for widths and the candidate struct.
`timescale 1ns / 1ps

module fwps_unpack
    import fwps_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  logic [BYTE_W-1:0]  xof_byte,
    input  logic               start_run,
    input  logic [EPOCH_W-1:0] epoch,
    output cand_t              cand
);

    localparam logic [BUF_W-1:0] LEFT_MASK = BUF_W'((1 << (POS_BITS - 1)) - 1);

    logic [BUF_W-1:0] buf_reg, buf_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [BIB_W-1:0] bib_reg, bib_next;

    logic [BUF_W-1:0] base_buf, merged, shifted;
    logic [CNT_W-1:0] base_cnt, merged_cnt, left_cnt;
    logic [BIB_W-1:0] base_bib;
    logic             has_pos;

    always_comb begin
        // a start request restarts the buffer before this byte goes in
        base_buf = start_run ? '0 : buf_reg;
        base_cnt = start_run ? '0 : cnt_reg;
        base_bib = start_run ? '0 : bib_reg;

        // append the byte above the held bits
        merged     = base_buf | (BUF_W'(xof_byte) << base_cnt);
        merged_cnt = base_cnt + CNT_W'(BYTE_W);
        has_pos    = merged_cnt >= CNT_W'(POS_BITS);

        shifted  = merged >> POS_BITS;
        left_cnt = merged_cnt - CNT_W'(POS_BITS);

        if (has_pos) begin
            buf_next = shifted;
            cnt_next = left_cnt;
            // keep at most POS_BITS-1 leftover bits
            if (left_cnt >= CNT_W'(POS_BITS)) begin
                cnt_next = CNT_W'(POS_BITS - 1);
                buf_next = shifted & LEFT_MASK;
            end
        end else begin
            buf_next = merged;
            cnt_next = merged_cnt;
        end

        // end of block drops the leftover bits
        if (base_bib == BIB_W'(BLOCK_BYTES - 1)) begin
            buf_next = '0;
            cnt_next = '0;
            bib_next = '0;
        end else begin
            bib_next = base_bib + BIB_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg <= '0;
            cnt_reg <= '0;
            bib_reg <= '0;
        end else if (accept) begin
            buf_reg <= buf_next;
            cnt_reg <= cnt_next;
            bib_reg <= bib_next;
        end
    end

    assign cand.pos     = merged[POS_BITS-1:0];
    assign cand.has_pos = has_pos;
    assign cand.start   = start_run;
    assign cand.epoch   = epoch;

endmodule

// File: rtl/fwps_clear.sv
// Run epoch tracking and visited-map clearing sweep.
// Depends on fwps_pkg for the epoch width and the map write struct.
`timescale 1ns / 1ps

module fwps_clear
    import fwps_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  logic               start_run,
    input  logic               start_pending,
    input  logic               s1_busy,
    output logic [EPOCH_W-1:0] item_epoch,
    output logic               hold,
    output logic               sweeping,
    output logic               sweep_start,
    output map_wr_t            sweep_wr
);

    logic [EPOCH_W-1:0]  epoch_reg, epoch_next;
    logic                sweep_reg, sweep_next;
    logic [POS_BITS-1:0] addr_reg, addr_next;
    logic                sweep_last;

    // a new run needs a fresh tag; out of tags means sweep first
    assign hold        = start_pending && (epoch_reg == EPOCH_MAX);
    assign sweep_start = hold && !sweep_reg && !s1_busy;
    assign sweep_last  = sweep_reg && (addr_reg == POS_BITS'(MAP_DEPTH - 1));
    assign item_epoch  = start_run ? epoch_reg + EPOCH_W'(1) : epoch_reg;

    always_comb begin
        epoch_next = epoch_reg;
        sweep_next = sweep_reg;
        addr_next  = addr_reg;
        if (sweep_reg) begin
            addr_next = addr_reg + POS_BITS'(1);
            if (sweep_last) begin
                sweep_next = 1'b0;
                epoch_next = EPOCH_FIRST;
            end
        end else if (sweep_start) begin
            sweep_next = 1'b1;
            addr_next  = '0;
        end else if (accept && start_run) begin
            epoch_next = item_epoch;
        end
    end

    // reset starts a full sweep since the RAM powers up unknown
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epoch_reg <= EPOCH_FIRST;
            sweep_reg <= 1'b1;
            addr_reg  <= '0;
        end else begin
            epoch_reg <= epoch_next;
            sweep_reg <= sweep_next;
            addr_reg  <= addr_next;
        end
    end

    assign sweeping      = sweep_reg;
    assign sweep_wr.en   = sweep_reg;
    assign sweep_wr.addr = addr_reg;
    assign sweep_wr.data = '0;

endmodule

// File: rtl/fwps_select.sv
// Duplicate filter and result register: map lookup, slot count, run end.
// Depends on fwps_pkg for the candidate and map write structs.
`timescale 1ns / 1ps

module fwps_select
    import fwps_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  cand_t                cand,
    input  logic [EPOCH_W-1:0]   rd_epoch,
    input  logic [FOUND_W-1:0]   weight_eff,
    input  logic                 fwd_flush,
    output logic                 s1_ready,
    output logic                 s1_busy,
    output map_wr_t              map_wr,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    cand_t s1_reg;
    logic  s1_valid_reg, s1_valid_next;

    logic                found_valid_reg;
    logic [FOUND_W-1:0]  found_reg, found_next;
    logic                done_reg, done_next;

    logic                fwd_valid_reg;
    logic [POS_BITS-1:0] fwd_addr_reg;
    logic [EPOCH_W-1:0]  fwd_epoch_reg;

    logic                m_valid_reg, m_valid_next;
    logic [POS_BITS-1:0] m_pos_reg;
    logic [SLOT_W-1:0]   m_slot_reg;
    logic                m_last_reg;

    logic [FOUND_W-1:0] found_eff, found_plus;
    logic               done_eff, visited, emit, out_free, s1_adv;

    // a start request opens a fresh run count
    assign found_eff  = s1_reg.start ? '0 : found_reg;
    assign done_eff   = s1_reg.start ? 1'b0 : done_reg;
    assign found_plus = found_eff + FOUND_W'(1);

    // tag match in the RAM, or the write that raced this item's read
    assign visited = (rd_epoch == s1_reg.epoch)
                  || (fwd_valid_reg && (fwd_addr_reg == s1_reg.pos)
                      && (fwd_epoch_reg == s1_reg.epoch));

    assign emit = s1_valid_reg && s1_reg.has_pos && !visited && !done_eff
               && (found_eff < weight_eff);

    assign out_free = !m_valid_reg || m_tready;
    assign s1_adv   = s1_valid_reg && (!emit || out_free);
    assign s1_ready = !s1_valid_reg || s1_adv;
    assign s1_busy  = s1_valid_reg;

    assign map_wr.en   = s1_adv && emit;
    assign map_wr.addr = s1_reg.pos;
    assign map_wr.data = s1_reg.epoch;

    always_comb begin
        found_next = emit ? found_plus : found_eff;
        done_next  = done_eff || (found_eff >= weight_eff)
                  || (emit && (found_plus >= weight_eff));
    end

    assign s1_valid_next = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign m_valid_next  = (s1_adv && emit) ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    // lookup stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg <= cand;
        end
    end

    // run bookkeeping, committed when the item leaves the lookup stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg       <= '0;
            done_reg        <= 1'b0;
            found_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            found_reg       <= found_next;
            done_reg        <= done_next;
            found_valid_reg <= 1'b1;
        end
    end

    // last map write, for the item whose read saw the old contents
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else if (fwd_flush) begin
            fwd_valid_reg <= 1'b0;
        end else if (map_wr.en) begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (map_wr.en) begin
            fwd_addr_reg  <= s1_reg.pos;
            fwd_epoch_reg <= s1_reg.epoch;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && emit) begin
            m_pos_reg  <= s1_reg.pos;
            m_slot_reg <= found_eff[SLOT_W-1:0];
            m_last_reg <= found_plus >= weight_eff;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({m_slot_reg, m_pos_reg});
    assign m_tlast  = m_last_reg && found_valid_reg;

endmodule

// File: rtl/fixed_weight_position_sampler_core.sv
// Fixed-weight position sampler: takes one hash-stream byte per cycle on the
// s_ stream, cuts each 168-byte block little-endian into ten-bit positions
// (the top 4 bits of the last byte are dropped) and emits each position the
// first time it shows up in a run, with its slot number, until the weight
// programmed over APB is reached (register 0, reset 44, capped at 64). A byte
// with s_tuser high opens a new run. Throughput is one byte per cycle unless a
// sweep, a tag hold or back-pressure on m_tready stalls it; a byte waits in the
// lookup stage register while the visited-map RAM read completes, and its
// result then goes to the result register that drives m_tvalid. The visited
// map is a 1024 x 6 RAM of run tags: after reset, and when the tags run out
// (once every 62 new runs), a sweep clears it while s_tready stays low.
// Depends on fwps_pkg, fwps_unpack, fwps_clear, fwps_map and fwps_select.
`timescale 1ns / 1ps

module fixed_weight_position_sampler_core
    import fwps_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] xof_byte
    input  logic                  s_tuser,   // [0] start_run
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [9:0] position, [15:10] slot
    output logic                  m_tlast,   // last
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [FOUND_W-1:0] weight_reg, weight_eff;
    logic               cfg_wr, accept, s1_ready, s1_busy;
    logic               hold, sweeping, sweep_start;
    logic [EPOCH_W-1:0] item_epoch, rd_epoch;
    cand_t              cand;
    map_wr_t            sel_wr, sweep_wr, mem_wr;

    // weight register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                 && (paddr[APB_ADDR_W-1:2] == REG_WEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg <= WEIGHT_RESET;
        end else if (cfg_wr) begin
            weight_reg <= pwdata[FOUND_W-1:0];
        end
    end

    assign prdata = (paddr[APB_ADDR_W-1:2] == REG_WEIGHT) ? APB_DATA_W'(weight_reg) : '0;
    assign weight_eff = (weight_reg > FOUND_W'(MAX_WEIGHT)) ? FOUND_W'(MAX_WEIGHT)
                                                          : weight_reg;

    // input handshake
    assign s_tready = s1_ready && !sweeping && !hold;
    assign accept   = s_tvalid && s_tready;

    fwps_clear u_clear (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .start_run     (s_tuser),
        .start_pending (s_tvalid && s_tuser),
        .s1_busy       (s1_busy),
        .item_epoch    (item_epoch),
        .hold          (hold),
        .sweeping      (sweeping),
        .sweep_start   (sweep_start),
        .sweep_wr      (sweep_wr)
    );

    fwps_unpack u_unpack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .xof_byte  (s_tdata),
        .start_run (s_tuser),
        .epoch     (item_epoch),
        .cand      (cand)
    );

    // sweep owns the write port while it runs
    assign mem_wr = sweeping ? sweep_wr : sel_wr;

    fwps_map u_map (
        .aclk    (aclk),
        .wr      (mem_wr),
        .rd_en   (accept),
        .rd_addr (cand.pos),
        .rd_data (rd_epoch)
    );

    fwps_select u_select (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .cand       (cand),
        .rd_epoch   (rd_epoch),
        .weight_eff (weight_eff),
        .fwd_flush  (sweep_start),
        .s1_ready   (s1_ready),
        .s1_busy    (s1_busy),
        .map_wr     (sel_wr),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    // the lookup stage never writes the map during a sweep
    assert property (@(posedge aclk) disable iff (!aresetn)
        sweeping |-> !sel_wr.en)
        else $error("map write from lookup stage during clearing sweep");

    // a sweep only begins once the lookup stage has drained
    assert property (@(posedge aclk) disable iff (!aresetn)
        sweep_start |-> !s1_busy)
        else $error("clearing sweep started with an item in the lookup stage");

    // accepted bytes never carry the cleared tag
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> (item_epoch != '0))
        else $error("accepted byte tagged with the cleared epoch");

endmodule
